// ----- rtl/tdts_pkg.sv -----
// Shared types, constants and character-class functions for the token scanner.
package tdts_pkg;

  // Default parameter values
  localparam int HEAD_CHARS_DEF = 8;
  localparam int LINE_BITS_DEF  = 16;

  // Fixed field widths
  localparam int CH_W       = 8;
  localparam int KWI_W      = 4;
  localparam int LEN_W      = 8;
  localparam int HEAD_W     = 64;
  localparam int LINE_OUT_W = 16;
  localparam int MAX_HEAD   = HEAD_W / 8;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Character codes with special handling
  localparam logic [CH_W-1:0] CH_LF   = 8'h0A;
  localparam logic [CH_W-1:0] CH_HASH = 8'h23;
  localparam logic [CH_W-1:0] CH_EQ   = 8'h3D;
  localparam logic [CH_W-1:0] CH_LT   = 8'h3C;
  localparam logic [CH_W-1:0] CH_GT   = 8'h3E;
  localparam logic [CH_W-1:0] CH_BANG = 8'h21;

  // Keyword table, stored as right-justified strings
  localparam int KW_COUNT = 13;
  localparam logic [HEAD_W-1:0] KW_TEXT [KW_COUNT] = '{
    "START", "FINISH", "THEN", "IF", "WHILE", "INT", "DO",
    "FREAD", "FPRINT", "VOID", "RETURN", "PROGRAM", "DUMMY"
  };
  localparam int KW_LEN [KW_COUNT] = '{5, 6, 4, 2, 5, 3, 2, 5, 6, 4, 6, 7, 5};

  // Token kinds
  typedef enum logic [2:0] {
    KIND_EOF     = 3'd0,
    KIND_IDENT   = 3'd1,
    KIND_NUMBER  = 3'd2,
    KIND_OPER    = 3'd3,
    KIND_DELIM   = 3'd4,
    KIND_REL     = 3'd5,
    KIND_KEYWORD = 3'd6,
    KIND_ERROR   = 3'd7
  } tok_kind_t;

  // Recognizer states
  typedef enum logic [3:0] {
    ST_START  = 4'd0,
    ST_IDENT  = 4'd1,
    ST_NUMBER = 4'd2,
    ST_OPER   = 4'd3,
    ST_DELIM  = 4'd4,
    ST_EQ     = 4'd5,
    ST_ANGLE  = 4'd6,
    ST_BANG   = 4'd7,
    ST_NE     = 4'd8,
    ST_EQREL  = 4'd9
  } dfa_state_t;

  // One queue entry: an optional finished token, optionally followed by eof
  typedef struct packed {
    logic                  tok;
    logic                  eof;
    tok_kind_t             kind;
    logic [LEN_W-1:0]      len;
    logic [HEAD_W-1:0]     head;
    logic [LINE_OUT_W-1:0] line;
  } scan_entry_t;

  function automatic logic is_alpha(input logic [CH_W-1:0] c);
    return (c inside {[8'h41:8'h5A], [8'h61:8'h7A]});
  endfunction

  function automatic logic is_digit(input logic [CH_W-1:0] c);
    return (c inside {[8'h30:8'h39]});
  endfunction

  // : + - * / %
  function automatic logic is_oper(input logic [CH_W-1:0] c);
    return (c inside {8'h3A, 8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h25});
  endfunction

  // . ( ) , { } ; [ ]
  function automatic logic is_delim(input logic [CH_W-1:0] c);
    return (c inside {8'h2E, 8'h28, 8'h29, 8'h2C, 8'h7B, 8'h7D, 8'h3B, 8'h5B, 8'h5D});
  endfunction

  // State entered when a character is seen from the start state
  function automatic dfa_state_t start_class(input logic [CH_W-1:0] c);
    dfa_state_t s;
    if (is_alpha(c))                      s = ST_IDENT;
    else if (is_digit(c))                 s = ST_NUMBER;
    else if (is_oper(c))                  s = ST_OPER;
    else if (is_delim(c))                 s = ST_DELIM;
    else if (c == CH_EQ)                  s = ST_EQ;
    else if (c == CH_LT || c == CH_GT)    s = ST_ANGLE;
    else if (c == CH_BANG)                s = ST_BANG;
    else                                  s = ST_START;
    return s;
  endfunction

  // Kind reported when a token ends in a given state
  function automatic tok_kind_t end_kind(input dfa_state_t s);
    tok_kind_t k;
    case (s)
      ST_IDENT:  k = KIND_IDENT;
      ST_NUMBER: k = KIND_NUMBER;
      ST_OPER:   k = KIND_OPER;
      ST_DELIM:  k = KIND_DELIM;
      ST_EQ:     k = KIND_OPER;
      ST_ANGLE:  k = KIND_REL;
      ST_BANG:   k = KIND_ERROR;
      ST_NE:     k = KIND_REL;
      ST_EQREL:  k = KIND_REL;
      default:   k = KIND_EOF;
    endcase
    return k;
  endfunction

endpackage

// ----- rtl/tdts_front.sv -----
// Front end: one character beat per cycle unless q_full; runs recognizer, queues tokens.
module tdts_front #(
  parameter int HEAD_CHARS = tdts_pkg::HEAD_CHARS_DEF,
  parameter int LINE_BITS  = tdts_pkg::LINE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [tdts_pkg::CH_W-1:0] ch,
  input  logic                      at_end,
  input  logic                      q_full,
  output logic                      push,
  output tdts_pkg::scan_entry_t     push_data
);
  import tdts_pkg::*;

  localparam int TEXT_W = 8 * HEAD_CHARS;

  // Recognizer registers
  dfa_state_t          state, state_next;
  logic [LEN_W-1:0]    lex_count, lex_count_next;
  logic [TEXT_W-1:0]   lex_text, lex_text_next;
  logic [LINE_BITS-1:0] line_count, line_count_next;
  logic                in_comment, in_comment_next;
  logic                pair_taken, pair_taken_next;

  logic                accept;
  logic                live;
  logic                cmt_drop;
  logic                joins;
  logic                ends;
  dfa_state_t          cls;
  logic [LEN_W-1:0]    app_count;
  logic [TEXT_W-1:0]   app_text;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign live     = (state != ST_START);
  assign cls      = start_class(ch);

  // Character appended to the current lexeme
  always_comb begin
    app_text = lex_text;
    for (int i = 0; i < HEAD_CHARS; i++) begin
      if (lex_count == LEN_W'(i)) app_text[8*i +: 8] = ch;
    end
    app_count = (lex_count == '1) ? lex_count : lex_count + 1'b1;
  end

  // Classify the beat: dropped by a comment, joins the token, or ends it
  always_comb begin
    cmt_drop = !at_end && ((in_comment && ch != CH_LF) || (!in_comment && ch == CH_HASH));
    joins = 1'b0;
    case (state)
      ST_IDENT:  joins = is_alpha(ch);
      ST_NUMBER: joins = is_digit(ch);
      ST_EQ:     joins = (ch == CH_EQ) || (ch == CH_LT) || (ch == CH_GT);
      ST_ANGLE:  joins = !pair_taken && ((ch == CH_LT) || (ch == CH_GT));
      ST_BANG:   joins = (ch == CH_EQ);
      default:   joins = 1'b0;
    endcase
    joins = joins && !at_end && !cmt_drop;
    ends  = at_end ? live : (!cmt_drop && !joins && live);
  end

  // Next state
  always_comb begin
    state_next      = state;
    lex_count_next  = lex_count;
    lex_text_next   = lex_text;
    line_count_next = line_count;
    in_comment_next = in_comment;
    pair_taken_next = pair_taken;
    if (accept) begin
      if (at_end) begin
        state_next      = ST_START;
        lex_count_next  = '0;
        lex_text_next   = '0;
        in_comment_next = 1'b0;
        pair_taken_next = 1'b0;
      end else if (cmt_drop) begin
        in_comment_next = 1'b1;
      end else if (joins) begin
        in_comment_next = 1'b0;
        lex_count_next  = app_count;
        lex_text_next   = app_text;
        case (state)
          ST_EQ:    state_next = ST_EQREL;
          ST_BANG:  state_next = ST_NE;
          ST_ANGLE: pair_taken_next = 1'b1;
          default:  state_next = state;
        endcase
      end else begin
        // token (if any) ends; character is rescanned from the start state
        in_comment_next = 1'b0;
        pair_taken_next = 1'b0;
        state_next      = cls;
        if (ch == CH_LF) line_count_next = line_count + 1'b1;
        if (cls != ST_START) begin
          lex_count_next = LEN_W'(1);
          lex_text_next  = TEXT_W'(ch);
        end else begin
          lex_count_next = '0;
          lex_text_next  = '0;
        end
      end
    end
  end

  // Queue write
  always_comb begin
    push           = accept && (at_end || ends);
    push_data.tok  = at_end ? live : 1'b1;
    push_data.eof  = at_end;
    push_data.kind = end_kind(state);
    push_data.len  = lex_count;
    push_data.head = HEAD_W'(lex_text);
    push_data.line = LINE_OUT_W'(line_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_START;
      lex_count  <= '0;
      lex_text   <= '0;
      line_count <= '0;
      in_comment <= 1'b0;
      pair_taken <= 1'b0;
    end else begin
      state      <= state_next;
      lex_count  <= lex_count_next;
      lex_text   <= lex_text_next;
      line_count <= line_count_next;
      in_comment <= in_comment_next;
      pair_taken <= pair_taken_next;
    end
  end

endmodule

// ----- rtl/tdts_queue.sv -----
// Short register queue between the front end and the back end.
module tdts_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  tdts_pkg::scan_entry_t push_data,
  input  logic                  pop,
  output tdts_pkg::scan_entry_t head,
  output logic                  empty,
  output logic                  full
);
  import tdts_pkg::*;

  scan_entry_t        slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  fill;
  logic               do_push;
  logic               do_pop;

  assign empty   = (fill == '0);
  assign full    = (fill == QCNT_W'(QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- rtl/tdts_back.sv -----
// Back end: keyword lookup, eof split and the output register.
module tdts_back #(
  parameter int HEAD_CHARS = tdts_pkg::HEAD_CHARS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  tdts_pkg::scan_entry_t           head,
  input  logic                            empty,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output tdts_pkg::tok_kind_t             token_kind,
  output logic [tdts_pkg::KWI_W-1:0]      keyword_index,
  output logic [tdts_pkg::LEN_W-1:0]      lexeme_length,
  output logic [tdts_pkg::HEAD_W-1:0]     lexeme_head,
  output logic [tdts_pkg::LINE_OUT_W-1:0] line_number,
  output logic                            is_last
);
  import tdts_pkg::*;

  function automatic logic [CH_W-1:0] upcase(input logic [CH_W-1:0] c);
    return (c inside {[8'h61:8'h7A]}) ? c - 8'h20 : c;
  endfunction

  // Case-insensitive match against the keyword table; 0 when none
  function automatic logic [KWI_W-1:0] kw_lookup(input logic [LEN_W-1:0] len,
                                                 input logic [HEAD_W-1:0] txt);
    logic [KWI_W-1:0] idx;
    logic             same;
    int               j;
    idx = '0;
    for (int k = 0; k < KW_COUNT; k++) begin
      same = (len == LEN_W'(KW_LEN[k])) && (KW_LEN[k] <= HEAD_CHARS);
      for (int i = 0; i < MAX_HEAD; i++) begin
        j = (i < KW_LEN[k]) ? KW_LEN[k] - 1 - i : 0;
        if (i < KW_LEN[k] && upcase(txt[8*i +: 8]) != KW_TEXT[k][8*j +: 8]) same = 1'b0;
      end
      if (same && idx == '0) idx = KWI_W'(k + 1);
    end
    return idx;
  endfunction

  logic             eof_phase;
  logic             load;
  logic             tok_first;
  logic [KWI_W-1:0] kwi;

  assign load      = !out_valid || out_ready;
  assign tok_first = head.tok && !eof_phase;
  assign kwi       = (head.kind == KIND_IDENT) ? kw_lookup(head.len, head.head) : '0;
  // a token followed by eof leaves the entry in place for a second beat
  assign pop       = load && !empty && !(tok_first && head.eof);

  // Eof phase marker
  always_ff @(posedge clk) begin
    if (rst) begin
      eof_phase <= 1'b0;
    end else if (load && !empty) begin
      eof_phase <= tok_first && head.eof;
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= !empty;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load && !empty) begin
      line_number <= head.line;
      if (tok_first) begin
        token_kind    <= (kwi != '0) ? KIND_KEYWORD : head.kind;
        keyword_index <= kwi;
        lexeme_length <= head.len;
        lexeme_head   <= head.head;
        is_last       <= !head.eof;
      end else begin
        token_kind    <= KIND_EOF;
        keyword_index <= '0;
        lexeme_length <= '0;
        lexeme_head   <= '0;
        is_last       <= 1'b1;
      end
    end
  end

endmodule

// ----- rtl/table_driven_token_scanner.sv -----
// Token scanner: one character beat in per cycle, up to two token beats out per character.
// The scanner accepts one character per clock for as long as its four-entry token queue has
// room; the recognizer step (class lookup, state update, lexeme append) is combinational
// logic in the front end, so the input rate is one beat per cycle. Tokens leave the back
// end through the queue and then an output register. An end-of-file beat that closes a
// pending token yields two output beats (the token, then eof) from one queue entry; the
// queue absorbs that extra beat and any output stall.
module table_driven_token_scanner #(
  parameter int HEAD_CHARS = tdts_pkg::HEAD_CHARS_DEF,
  parameter int LINE_BITS  = tdts_pkg::LINE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  logic [0:0]  s_axis_tuser,   // [0] at_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // [3:0] keyword_index, [11:4] lexeme_length,
                                      // [75:12] lexeme_head, [91:76] line_number, rest 0
  output logic [2:0]  m_axis_tuser,   // [2:0] token_kind
  output logic        m_axis_tlast    // is_last
);
  import tdts_pkg::*;

  logic                  q_full;
  logic                  q_empty;
  logic                  push;
  logic                  pop;
  scan_entry_t           push_data;
  scan_entry_t           q_head;
  tok_kind_t             token_kind;
  logic [KWI_W-1:0]      keyword_index;
  logic [LEN_W-1:0]      lexeme_length;
  logic [HEAD_W-1:0]     lexeme_head;
  logic [LINE_OUT_W-1:0] line_number;

  tdts_front #(
    .HEAD_CHARS (HEAD_CHARS),
    .LINE_BITS  (LINE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .ch        (s_axis_tdata),
    .at_end    (s_axis_tuser[0]),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  tdts_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  tdts_back #(
    .HEAD_CHARS (HEAD_CHARS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (q_head),
    .empty         (q_empty),
    .pop           (pop),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .token_kind    (token_kind),
    .keyword_index (keyword_index),
    .lexeme_length (lexeme_length),
    .lexeme_head   (lexeme_head),
    .line_number   (line_number),
    .is_last       (m_axis_tlast)
  );

  // Output beat packing
  assign m_axis_tdata = {4'b0000, line_number, lexeme_head, lexeme_length, keyword_index};
  assign m_axis_tuser = token_kind;

endmodule
